@@ rtl/expodec_pkg.sv @@
// package: constants and fraction table generator for the expodec window value block
package expodec_pkg;

   localparam logic [35:0] LOG2_1000_Q32 = 36'd42802717582;
   localparam logic [31:0] LN2_Q32       = 32'd2977044472;
   localparam logic [32:0] Q32_ONE       = 33'h1_0000_0000;
   localparam int          SERIES_TERMS  = 20;

   // divide by a small series index
   function automatic logic [63:0] div_small(input logic [63:0] v, input logic [4:0] n);
      logic [63:0] q;
      unique case (n)
         5'd2:    q = v / 2;
         5'd3:    q = v / 3;
         5'd4:    q = v / 4;
         5'd5:    q = v / 5;
         5'd6:    q = v / 6;
         5'd7:    q = v / 7;
         5'd8:    q = v / 8;
         5'd9:    q = v / 9;
         5'd10:   q = v / 10;
         5'd11:   q = v / 11;
         5'd12:   q = v / 12;
         5'd13:   q = v / 13;
         5'd14:   q = v / 14;
         5'd15:   q = v / 15;
         5'd16:   q = v / 16;
         5'd17:   q = v / 17;
         5'd18:   q = v / 18;
         5'd19:   q = v / 19;
         5'd20:   q = v / 20;
         default: q = v;
      endcase
      return q;
   endfunction

   // 2^(-y) for y in [0,1) in Q0.32, result in Q1.32
   function automatic logic [32:0] pow2_neg_q32(input logic [31:0] y);
      logic [63:0] z;
      logic [63:0] term;
      logic [63:0] sum;
      z    = (64'(y) * 64'(LN2_Q32)) >> 32;
      term = 64'(Q32_ONE);
      sum  = 64'(Q32_ONE);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = div_small((term * z) >> 32, 5'(n));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return (sum > 64'(Q32_ONE)) ? Q32_ONE : sum[32:0];
   endfunction

endpackage

@@ rtl/expodec_window_value_top.sv @@
// top level: pipelined exponential attack/decay window value
//
//  port group  dir   handshake              payload (lsb up)
//  req_*       in    req_tvalid/req_tready  req_tdata: position
//  rsp_*       out   rsp_tvalid/rsp_tready  rsp_tdata: window_value
//  csr_*       in    csr_wr_en              csr_wr_data: peak_ratio
//
// one word per cycle sustained while rsp_tready stays high; the divider
// resolves one quotient bit per stage
// reset clears all stage valid bits and sets peak_ratio to one lsb
// a stage holds only while it is full and the stage after it holds,
// so a stalled output freezes the tail while bubbles ahead still fill
module expodec_window_value_top #(
   parameter int FRAC_BITS       = 16,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] req_tdata,   // position
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] rsp_tdata,   // window_value
   input  logic                                   csr_wr_en,
   input  logic [FRAC_BITS:0]                     csr_wr_data   // peak_ratio
);
   import expodec_pkg::*;

   localparam int VAL_W      = FRAC_BITS + 1;
   localparam int DATA_W     = ((VAL_W + 7) / 8) * 8;
   localparam int IDX_W      = $clog2(EXP_TABLE_DEPTH);
   localparam int NUM_DIV    = FRAC_BITS + 1;
   localparam int SHIFT_BASE = 32 - FRAC_BITS;
   localparam logic [VAL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // fraction table and slopes
   logic [32:0] tab_a [EXP_TABLE_DEPTH];
   logic [31:0] tab_d [EXP_TABLE_DEPTH];

   for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
      localparam logic [31:0] YA = 32'((64'(k) << 32) / EXP_TABLE_DEPTH);
      localparam logic [31:0] YB = 32'((64'(k + 1) << 32) / EXP_TABLE_DEPTH);
      localparam logic [32:0] TA = pow2_neg_q32(YA);
      localparam logic [32:0] TB = (k + 1 == EXP_TABLE_DEPTH) ? (Q32_ONE >> 1)
                                                               : pow2_neg_q32(YB);
      localparam logic [32:0] TD = TA - TB;
      assign tab_a[k] = TA;
      assign tab_d[k] = TD[31:0];
   end

   // configuration
   logic [VAL_W-1:0] peak_ratio_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ratio_ff <= VAL_W'(1);
      end else if (csr_wr_en) begin
         peak_ratio_ff <= csr_wr_data;
      end
   end

   // stage enables
   logic               p0_en, p1_en, p2_en, p3_en, p4_en, p5_en, p6_en, out_en;
   logic [NUM_DIV-1:0] div_en;

   // input stage: clip and pick the divide
   logic             p0_v_ff;
   logic [VAL_W-1:0] p0_num_ff, p0_den_ff;
   logic             p0_br_ff;
   logic [VAL_W-1:0] x_clip, r_clip, p0_num_in, p0_den_in;
   logic             p0_br_in;

   always_comb begin
      x_clip = req_tdata[VAL_W-1:0];
      if (x_clip > ONE) begin
         x_clip = ONE;
      end
      priority if (peak_ratio_ff == '0) begin
         r_clip = VAL_W'(1);
      end else if (peak_ratio_ff > ONE) begin
         r_clip = ONE;
      end else begin
         r_clip = peak_ratio_ff;
      end
      p0_br_in  = x_clip > r_clip;
      p0_num_in = p0_br_in ? x_clip - r_clip : x_clip;
      p0_den_in = p0_br_in ? ONE - r_clip : r_clip;
   end

   assign p0_en      = !p0_v_ff || div_en[0];
   assign req_tready = p0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_v_ff <= 1'b0;
      end else if (p0_en) begin
         p0_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (p0_en) begin
         p0_num_ff <= p0_num_in;
         p0_den_ff <= p0_den_in;
         p0_br_ff  <= p0_br_in;
      end
   end

   // restoring divider, one quotient bit per stage
   logic             div_v_ff   [NUM_DIV];
   logic [VAL_W-1:0] div_rem_ff [NUM_DIV];
   logic [VAL_W-1:0] div_den_ff [NUM_DIV];
   logic [VAL_W-1:0] div_q_ff   [NUM_DIV];
   logic             div_br_ff  [NUM_DIV];

   for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
      logic             v_src;
      logic [VAL_W-1:0] rem_src, den_src, q_src;
      logic             br_src;
      logic [VAL_W:0]   trial;
      logic             qbit;
      logic [VAL_W:0]   rem_next;

      if (k == 0) begin : g_first
         assign v_src   = p0_v_ff;
         assign rem_src = p0_num_ff;
         assign den_src = p0_den_ff;
         assign q_src   = '0;
         assign br_src  = p0_br_ff;
         assign trial   = {1'b0, rem_src};
      end else begin : g_next
         assign v_src   = div_v_ff[k-1];
         assign rem_src = div_rem_ff[k-1];
         assign den_src = div_den_ff[k-1];
         assign q_src   = div_q_ff[k-1];
         assign br_src  = div_br_ff[k-1];
         assign trial   = {rem_src, 1'b0};
      end

      if (k == NUM_DIV - 1) begin : g_en_last
         assign div_en[k] = !div_v_ff[k] || p1_en;
      end else begin : g_en_mid
         assign div_en[k] = !div_v_ff[k] || div_en[k+1];
      end

      assign qbit     = trial >= {1'b0, den_src};
      assign rem_next = qbit ? trial - {1'b0, den_src} : trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k] <= 1'b0;
         end else if (div_en[k]) begin
            div_v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (div_en[k]) begin
            div_rem_ff[k] <= rem_next[VAL_W-1:0];
            div_den_ff[k] <= den_src;
            div_q_ff[k]   <= {q_src[VAL_W-2:0], qbit};
            div_br_ff[k]  <= br_src;
         end
      end
   end

   // t from quotient
   logic             p1_v_ff;
   logic [VAL_W-1:0] p1_t_ff, p1_t_in, q_last;

   assign q_last  = div_q_ff[NUM_DIV-1];
   assign p1_t_in = div_br_ff[NUM_DIV-1] ? ((q_last > ONE) ? ONE : q_last) : ONE - q_last;
   assign p1_en   = !p1_v_ff || p2_en;

   // exponent log2(1000) * t
   logic        p2_v_ff;
   logic [3:0]  p2_n_ff;
   logic [31:0] p2_fr_ff;
   logic [63:0] e_prod, e_full;

   assign e_prod = 64'(p1_t_ff) * 64'(LOG2_1000_Q32);
   assign e_full = e_prod >> FRAC_BITS;
   assign p2_en  = !p2_v_ff || p3_en;

   // table position
   logic             p3_v_ff;
   logic [3:0]       p3_n_ff;
   logic [IDX_W-1:0] p3_idx_ff;
   logic [31:0]      p3_rem_ff;
   logic [63:0]      pos;

   assign pos   = 64'(p2_fr_ff) * 64'(EXP_TABLE_DEPTH);
   assign p3_en = !p3_v_ff || p4_en;

   // table read
   logic        p4_v_ff;
   logic [3:0]  p4_n_ff;
   logic [32:0] p4_a_ff;
   logic [31:0] p4_d_ff, p4_rem_ff;

   assign p4_en = !p4_v_ff || p5_en;

   // slope times remainder
   logic        p5_v_ff;
   logic [3:0]  p5_n_ff;
   logic [32:0] p5_a_ff;
   logic [31:0] p5_hi_ff;
   logic [63:0] slope_prod;

   assign slope_prod = 64'(p4_d_ff) * 64'(p4_rem_ff);
   assign p5_en      = !p5_v_ff || p6_en;

   // interpolated value
   logic        p6_v_ff;
   logic [3:0]  p6_n_ff;
   logic [32:0] p6_val_ff;

   assign p6_en = !p6_v_ff || out_en;

   // round, shift and saturate
   logic             rsp_v_ff;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [5:0]       shift_amt;
   logic [33:0]      rnd_sum, y_full;

   assign shift_amt    = 6'(p6_n_ff) + 6'(SHIFT_BASE);
   assign rnd_sum      = 34'(p6_val_ff) + (34'(1) << (shift_amt - 6'd1));
   assign y_full       = rnd_sum >> shift_amt;
   assign rsp_value_in = (y_full > 34'(ONE)) ? ONE : y_full[VAL_W-1:0];
   assign out_en       = !rsp_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
         p3_v_ff  <= 1'b0;
         p4_v_ff  <= 1'b0;
         p5_v_ff  <= 1'b0;
         p6_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (p1_en) begin
            p1_v_ff <= div_v_ff[NUM_DIV-1];
         end
         if (p2_en) begin
            p2_v_ff <= p1_v_ff;
         end
         if (p3_en) begin
            p3_v_ff <= p2_v_ff;
         end
         if (p4_en) begin
            p4_v_ff <= p3_v_ff;
         end
         if (p5_en) begin
            p5_v_ff <= p4_v_ff;
         end
         if (p6_en) begin
            p6_v_ff <= p5_v_ff;
         end
         if (out_en) begin
            rsp_v_ff <= p6_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p1_en) begin
         p1_t_ff <= p1_t_in;
      end
      if (p2_en) begin
         p2_n_ff  <= e_full[35:32];
         p2_fr_ff <= e_full[31:0];
      end
      if (p3_en) begin
         p3_n_ff   <= p2_n_ff;
         p3_idx_ff <= pos[32 +: IDX_W];
         p3_rem_ff <= pos[31:0];
      end
      if (p4_en) begin
         p4_n_ff   <= p3_n_ff;
         p4_a_ff   <= tab_a[p3_idx_ff];
         p4_d_ff   <= tab_d[p3_idx_ff];
         p4_rem_ff <= p3_rem_ff;
      end
      if (p5_en) begin
         p5_n_ff  <= p4_n_ff;
         p5_a_ff  <= p4_a_ff;
         p5_hi_ff <= slope_prod[63:32];
      end
      if (p6_en) begin
         p6_n_ff   <= p5_n_ff;
         p6_val_ff <= p5_a_ff - 33'(p5_hi_ff);
      end
      if (out_en) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = DATA_W'(rsp_value_ff);

   // checks
   a_accept_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> p0_v_ff)
      else $error("accepted word did not reach the input stage");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      p0_v_ff |-> p0_den_ff != '0 && p0_num_ff <= p0_den_ff)
      else $error("divider operands out of range");

   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      div_v_ff[NUM_DIV-1] |-> div_q_ff[NUM_DIV-1] <= ONE
                              && div_rem_ff[NUM_DIV-1] < div_den_ff[NUM_DIV-1])
      else $error("quotient or remainder out of range");

   a_exponent_range: assert property (@(posedge clock) disable iff (reset)
      p2_v_ff |-> p2_n_ff <= 4'd9)
      else $error("exponent integer part too large");

   a_output_range: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> rsp_value_ff <= ONE)
      else $error("window value above one");

endmodule
